>>> design/msvm_pkg.sv
// Shared types and constants for the matrix store / vector multiply block.
// No dependencies; compile first.
package msvm_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int ELEM_W      = 16;
    localparam int VALUE_W     = 40;
    localparam int CMD_W       = 3;
    localparam int FIELD_IDX_W = 4;

    localparam logic [CFG_W-1:0]     SIZE_RST = 5'd16;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_MULT  = 3'd3,
        CMD_RMAX  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        OP_IMM,
        OP_READ,
        OP_MAC,
        OP_MAX
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        t_op  op;
        logic first;
        logic last_col;
        logic last;
        logic status;
    } t_tag;

endpackage

>>> design/msvm_if.sv
// Channel interfaces: request, result and register write.
// Depends on msvm_pkg.
interface msvm_req_if;
    import msvm_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [CMD_W-1:0]              command;
    logic [FIELD_IDX_W-1:0]        row_index;
    logic [FIELD_IDX_W-1:0]        col_index;
    logic signed [ELEM_W-1:0]      element_value;
    modport source(output valid, command, row_index, col_index, element_value, input ready);
    modport sink(input valid, command, row_index, col_index, element_value, output ready);
endinterface

interface msvm_rsp_if;
    import msvm_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_W-1:0]     value;
    logic                          status;
    logic [FIELD_IDX_W-1:0]        result_row;
    logic                          last;
    modport source(output valid, value, status, result_row, last, input ready);
    modport sink(input valid, value, status, result_row, last, output ready);
endinterface

interface msvm_cfg_if;
    import msvm_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [CFG_IDX_W-1:0]          reg_index;
    logic [CFG_W-1:0]              wr_data;
    modport source(output valid, reg_index, wr_data, input ready);
    modport sink(input valid, reg_index, wr_data, output ready);
endinterface

>>> design/matrix_store_vector_multiply.sv
// Matrix store with vector multiply and row maxima, one shared MAC/compare unit.
// Depends on msvm_pkg and the channel interfaces in msvm_if.sv.
//
// Usage:
//   i_req takes one request per command: write element, read element, load
//   vector entry, multiply, row maxima. o_rsp returns one result per write,
//   read, load or bad request, and one result per row in use for multiply and
//   row maxima, the final one flagged by last. i_cfg writes rows_in_use
//   (index 0) and cols_in_use (index 1); it is always ready.
// Timing:
//   A sequencer issues one matrix element per cycle while o_rsp is not
//   stalled, into a three-stage path (memory read, multiply or extend,
//   accumulate or compare). Write, read and load issue a single element;
//   multiply and row maxima issue rows*cols elements. i_req is ready again
//   right after the last issue; the last result follows through the stages.
// Reset and register writes:
//   After reset, and after every write to rows_in_use or cols_in_use, a
//   clearing pass zeroes all MAX_DIM*MAX_DIM matrix elements, one per cycle,
//   while i_req is held not ready. The vector valid flags clear at reset only.
// Stall:
//   While a result waits on o_rsp, the whole issue and compute path holds.
module matrix_store_vector_multiply
    import msvm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msvm_req_if.sink   i_req,
    msvm_rsp_if.source o_rsp,
    msvm_cfg_if.sink   i_cfg
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SIZE_W = $clog2(MAX_DIM + 1);
    localparam int CW     = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
    localparam int XW     = (SIZE_W > FIELD_IDX_W) ? SIZE_W : FIELD_IDX_W;
    localparam int EXT_W  = VALUE_W - ELEM_W - 8;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_rows, r_cols;
    logic [SIZE_W-1:0] nr, nc;
    logic [CW-1:0]     rows_x, cols_x;

    logic [ADDR_W-1:0] r_clr_addr;
    logic              clr_done;

    logic [IDX_W-1:0]  r_row, r_col;
    t_op               r_op;
    logic              r_status;

    logic              req_ready, s0_vld, clearing;
    logic              accept, cfg_wr, adv;
    logic              row_ok, col_ok;
    t_tag              s0_tag;
    logic [IDX_W-1:0]  s0_row;
    logic [ADDR_W-1:0] s0_addr;
    logic              s0_col_last, s0_row_last;

    logic signed [ELEM_W-1:0] r_mat [DEPTH];
    logic signed [ELEM_W-1:0] r_vec [MAX_DIM];
    logic [MAX_DIM-1:0]       r_vec_vld;

    logic                     mat_we;
    logic [ADDR_W-1:0]        mat_waddr;
    logic signed [ELEM_W-1:0] mat_wdata;
    logic                     vec_we;
    logic [IDX_W-1:0]         req_row, req_col;

    logic                     r_s1_vld, r_s2_vld;
    t_tag                     r_s1_tag, r_s2_tag;
    logic [IDX_W-1:0]         r_s1_row, r_s2_row;
    logic signed [ELEM_W-1:0] r_mem_q, r_vec_q;
    logic                     r_vec_ok;
    logic signed [ELEM_W-1:0] vec_op;
    logic signed [31:0]       prod;
    logic signed [VALUE_W-1:0] elem_x;
    logic signed [VALUE_W-1:0] r_s2_val, r_acc, acc_next;

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_status;
    logic [FIELD_IDX_W-1:0]    r_out_row;
    logic                      r_out_last;

    // Effective sizes
    always_comb begin
        rows_x = CW'(r_rows);
        cols_x = CW'(r_cols);
        if (rows_x == '0) begin
            nr = SIZE_W'(1);
        end else if (rows_x > CW'(MAX_DIM)) begin
            nr = SIZE_W'(MAX_DIM);
        end else begin
            nr = SIZE_W'(rows_x);
        end
        if (cols_x == '0) begin
            nc = SIZE_W'(1);
        end else if (cols_x > CW'(MAX_DIM)) begin
            nc = SIZE_W'(MAX_DIM);
        end else begin
            nc = SIZE_W'(cols_x);
        end
    end

    assign cfg_wr  = i_cfg.valid && i_cfg.ready &&
                     (i_cfg.reg_index == REG_ROWS || i_cfg.reg_index == REG_COLS);
    assign accept  = i_req.valid && req_ready;
    assign adv     = !r_out_valid || o_rsp.ready;
    assign clr_done = (r_clr_addr == ADDR_W'(DEPTH - 1));

    assign row_ok  = XW'(i_req.row_index) < XW'(nr);
    assign col_ok  = XW'(i_req.col_index) < XW'(nc);
    assign req_row = IDX_W'(i_req.row_index);
    assign req_col = IDX_W'(i_req.col_index);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (clr_done) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_WALK;
            ST_WALK:  if (adv && s0_tag.last) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
        if (cfg_wr) n_state = ST_CLEAR;
    end

    // State outputs
    always_comb begin
        req_ready = 1'b0;
        s0_vld    = 1'b0;
        clearing  = 1'b0;
        unique case (r_state)
            ST_CLEAR: clearing  = 1'b1;
            ST_IDLE:  req_ready = 1'b1;
            ST_WALK:  s0_vld    = 1'b1;
            default:  req_ready = 1'b0;
        endcase
    end

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;

    // Issue stage
    always_comb begin
        s0_col_last = (r_col == IDX_W'(nc - SIZE_W'(1)));
        s0_row_last = (r_row == IDX_W'(nr - SIZE_W'(1)));
        s0_addr     = ADDR_W'(r_row * MAX_DIM) + ADDR_W'(r_col);
        s0_tag.op   = r_op;
        s0_tag.status = r_status;
        if (r_op == OP_MAC || r_op == OP_MAX) begin
            s0_tag.first    = (r_col == '0);
            s0_tag.last_col = s0_col_last;
            s0_tag.last     = s0_col_last && s0_row_last;
            s0_row          = r_row;
        end else begin
            s0_tag.first    = 1'b1;
            s0_tag.last_col = 1'b1;
            s0_tag.last     = 1'b1;
            s0_row          = '0;
        end
    end

    // Store writes
    always_comb begin
        mat_we    = 1'b0;
        mat_waddr = ADDR_W'(req_row * MAX_DIM) + ADDR_W'(req_col);
        mat_wdata = i_req.element_value;
        vec_we    = 1'b0;
        if (clearing) begin
            mat_we    = 1'b1;
            mat_waddr = r_clr_addr;
            mat_wdata = '0;
        end else if (accept) begin
            mat_we = (i_req.command == CMD_WRITE) && row_ok && col_ok;
            vec_we = (i_req.command == CMD_LOAD) && col_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mat_we) r_mat[mat_waddr] <= mat_wdata;
        if (adv) r_mem_q <= r_mat[s0_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) r_vec[req_col] <= i_req.element_value;
        if (adv) r_vec_q <= r_vec[r_col];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rows      <= SIZE_RST;
            r_cols      <= SIZE_RST;
            r_clr_addr  <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_op        <= OP_IMM;
            r_status    <= 1'b0;
            r_vec_vld   <= '0;
            r_vec_ok    <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                if (i_cfg.reg_index == REG_ROWS) r_rows <= i_cfg.wr_data;
                else r_cols <= i_cfg.wr_data;
                r_clr_addr <= '0;
            end else if (clearing && !clr_done) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (vec_we) r_vec_vld[req_col] <= 1'b1;
            if (accept) begin
                r_row    <= '0;
                r_col    <= '0;
                r_op     <= OP_IMM;
                r_status <= 1'b0;
                case (i_req.command)
                    CMD_WRITE: r_status <= !(row_ok && col_ok);
                    CMD_READ: begin
                        if (row_ok && col_ok) begin
                            r_op  <= OP_READ;
                            r_row <= req_row;
                            r_col <= req_col;
                        end else begin
                            r_status <= 1'b1;
                        end
                    end
                    CMD_LOAD: r_status <= !col_ok;
                    CMD_MULT: r_op <= OP_MAC;
                    CMD_RMAX: r_op <= OP_MAX;
                    default:  r_status <= 1'b1;
                endcase
            end else if (s0_vld && adv && !s0_tag.last_col) begin
                r_col <= r_col + IDX_W'(1);
            end else if (s0_vld && adv && !s0_tag.last) begin
                r_col <= '0;
                r_row <= r_row + IDX_W'(1);
            end
            if (adv) begin
                r_vec_ok    <= r_vec_vld[r_col];
                r_s1_vld    <= s0_vld;
                r_s2_vld    <= r_s1_vld;
                r_out_valid <= r_s2_vld && r_s2_tag.last_col;
            end
        end
    end

    // Shared multiply / extend and accumulate / compare
    assign vec_op = r_vec_ok ? r_vec_q : '0;
    assign prod   = r_mem_q * vec_op;
    assign elem_x = {{EXT_W{r_mem_q[ELEM_W-1]}}, r_mem_q, 8'h00};

    always_comb begin
        if (r_s2_tag.first) begin
            acc_next = r_s2_val;
        end else if (r_s2_tag.op == OP_MAX) begin
            acc_next = (r_s2_val > r_acc) ? r_s2_val : r_acc;
        end else begin
            acc_next = r_acc + r_s2_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_tag <= s0_tag;
            r_s1_row <= s0_row;
            r_s2_tag <= r_s1_tag;
            r_s2_row <= r_s1_row;
            case (r_s1_tag.op)
                OP_MAC:            r_s2_val <= VALUE_W'(prod);
                OP_MAX, OP_READ:   r_s2_val <= elem_x;
                default:           r_s2_val <= '0;
            endcase
            if (r_s2_vld) begin
                r_acc <= acc_next;
                if (r_s2_tag.last_col) begin
                    r_out_value  <= acc_next;
                    r_out_status <= r_s2_tag.status;
                    r_out_row    <= FIELD_IDX_W'(r_s2_row);
                    r_out_last   <= r_s2_tag.last;
                end
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.value      = r_out_value;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.result_row = r_out_row;
    assign o_rsp.last       = r_out_last;

endmodule
